// ===== rtl/core/ring_queue_batch_pop_assert.svh =====
// Assertion macros for the ring queue block.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef RING_QUEUE_BATCH_POP_ASSERT_SVH
`define RING_QUEUE_BATCH_POP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define RQBP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ring queue check failed");

// Consequent must hold in the cycle after the antecedent
`define RQBP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ring queue check failed");

`endif

// ===== rtl/core/rqbp_pkg.sv =====
package rqbp_pkg;

    // Ring geometry
    localparam int RING_SIZE = 64;
    localparam int WORD_BITS = 32;
    localparam int PTR_W     = (RING_SIZE > 1) ? $clog2(RING_SIZE) : 1;

    // Field widths fixed by the interface
    localparam int CNT_W    = 7;
    localparam int STATUS_W = 2;
    localparam int CMP_W    = (PTR_W > CNT_W) ? PTR_W : CNT_W;
    localparam int SUM_W    = CMP_W + 1;

    // Most words one pop may return
    localparam int RESULT_CAP = 64;
    localparam int MAX_GRANT  = (RING_SIZE < RESULT_CAP) ? RING_SIZE : RESULT_CAP;

    // Command codes
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_POPPED   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PUSH_OK  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NONE     = 2'd3;

    // Result descriptor leaving the controller; word data from the ring memory joins it in the same cycle
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CNT_W-1:0]    granted;
        logic                last;
        logic                from_ram;
    } res_t;

    // Complete output beat
    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [WORD_BITS-1:0] value;
        logic [CNT_W-1:0]     granted;
        logic                 last;
    } beat_t;

    // Advance a ring position with wraparound; by never exceeds RING_SIZE
    function automatic logic [PTR_W-1:0] adv_pos(input logic [PTR_W-1:0] pos,
                                                 input logic [CNT_W-1:0] by);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(pos) + SUM_W'(by);
        if (sum >= SUM_W'(RING_SIZE))
        begin
            sum = sum - SUM_W'(RING_SIZE);
        end
        return sum[PTR_W-1:0];
    endfunction

endpackage

// ===== rtl/core/rqbp_ram.sv =====
module rqbp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                 wr_data,
    input  logic                             rd_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
    output logic [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/rqbp_ctrl.sv =====
module rqbp_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           command,
    input  logic [rqbp_pkg::WORD_BITS-1:0] push_value,
    input  logic [rqbp_pkg::CNT_W-1:0]     min_count,
    input  logic [rqbp_pkg::CNT_W-1:0]     max_count,
    input  logic                           room,
    output logic                           busy,
    output logic                           ram_wr_en,
    output logic [rqbp_pkg::PTR_W-1:0]     ram_wr_addr,
    output logic [rqbp_pkg::WORD_BITS-1:0] ram_wr_data,
    output logic                           ram_rd_en,
    output logic [rqbp_pkg::PTR_W-1:0]     ram_rd_addr,
    output logic                           res_valid,
    output rqbp_pkg::res_t                 res
);
    import rqbp_pkg::*;

    logic [PTR_W-1:0] wr_pos_reg, wr_pos_next;
    logic [PTR_W-1:0] rd_pos_reg, rd_pos_next;
    logic             busy_reg, busy_next;
    logic [PTR_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] remain_reg, remain_next;
    logic [CNT_W-1:0] granted_reg, granted_next;
    logic             res_valid_reg, res_valid_next;
    res_t             res_reg, res_next;

    logic             accept;
    logic [PTR_W-1:0] wr_adv;
    logic             full;
    logic [SUM_W-1:0] avail_sum;
    logic [PTR_W-1:0] avail;
    logic [CNT_W-1:0] max_clamp;
    logic [CMP_W-1:0] avail_ext;
    logic [CMP_W-1:0] max_ext;
    logic [CMP_W-1:0] grant_ext;
    logic [CNT_W-1:0] grant;
    logic             pop_none;

    assign in_stall = busy_reg | ~room;
    assign accept   = in_valid & ~in_stall;
    assign busy     = busy_reg;

    // Occupancy and grant size of a pop
    assign wr_adv    = adv_pos(wr_pos_reg, CNT_W'(1));
    assign full      = (wr_adv == rd_pos_reg);
    assign avail_sum = SUM_W'(wr_pos_reg) - SUM_W'(rd_pos_reg)
                     + ((rd_pos_reg <= wr_pos_reg) ? '0 : SUM_W'(RING_SIZE));
    assign avail     = avail_sum[PTR_W-1:0];
    assign max_clamp = (max_count > CNT_W'(MAX_GRANT)) ? CNT_W'(MAX_GRANT) : max_count;
    assign avail_ext = CMP_W'(avail);
    assign max_ext   = CMP_W'(max_clamp);
    assign grant_ext = (avail_ext > max_ext) ? max_ext : avail_ext;
    assign grant     = grant_ext[CNT_W-1:0];
    assign pop_none  = (avail_ext < CMP_W'(min_count)) | (grant == '0);

    // Memory write on an accepted push into a ring with space
    assign ram_wr_en   = accept & (command == CMD_PUSH) & ~full;
    assign ram_wr_addr = wr_pos_reg;
    assign ram_wr_data = push_value;

    // Sequencer: push/none answer at once, pop reads one word per cycle while the output queue has room
    always_comb
    begin
        wr_pos_next    = wr_pos_reg;
        rd_pos_next    = rd_pos_reg;
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        remain_next    = remain_reg;
        granted_next   = granted_reg;
        res_valid_next = 1'b0;
        res_next       = res_reg;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = busy_reg ? idx_reg : rd_pos_reg;

        if (busy_reg)
        begin
            if (room)
            begin
                ram_rd_en      = 1'b1;
                res_valid_next = 1'b1;
                res_next       = '{status: ST_POPPED, granted: granted_reg,
                                   last: (remain_reg == CNT_W'(1)), from_ram: 1'b1};
                idx_next       = adv_pos(idx_reg, CNT_W'(1));
                remain_next    = remain_reg - CNT_W'(1);
                if (remain_reg == CNT_W'(1))
                begin
                    busy_next = 1'b0;
                end
            end
        end
        else if (accept)
        begin
            res_valid_next = 1'b1;
            if (command == CMD_PUSH)
            begin
                res_next = '{status: full ? ST_OVERFLOW : ST_PUSH_OK, granted: '0,
                             last: 1'b1, from_ram: 1'b0};
                if (!full)
                begin
                    wr_pos_next = wr_adv;
                end
            end
            else if (pop_none)
            begin
                res_next = '{status: ST_NONE, granted: '0, last: 1'b1, from_ram: 1'b0};
            end
            else
            begin
                // first word is read in the accept cycle
                ram_rd_en    = 1'b1;
                res_next     = '{status: ST_POPPED, granted: grant,
                                 last: (grant == CNT_W'(1)), from_ram: 1'b1};
                rd_pos_next  = adv_pos(rd_pos_reg, grant);
                idx_next     = adv_pos(rd_pos_reg, CNT_W'(1));
                remain_next  = grant - CNT_W'(1);
                granted_next = grant;
                busy_next    = (grant != CNT_W'(1));
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_pos_reg    <= '0;
            rd_pos_reg    <= '0;
            busy_reg      <= 1'b0;
            remain_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            wr_pos_reg    <= wr_pos_next;
            rd_pos_reg    <= rd_pos_next;
            busy_reg      <= busy_next;
            remain_reg    <= remain_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload state
    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        granted_reg <= granted_next;
        res_reg     <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== rtl/core/rqbp_outq.sv =====
module rqbp_outq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            enq_valid,
    input  rqbp_pkg::beat_t enq_beat,
    output logic            out_valid,
    input  logic            out_stall,
    output rqbp_pkg::beat_t out_beat,
    output logic [1:0]      count,
    output logic            deq
);
    import rqbp_pkg::*;

    beat_t      q_mem_reg [2];
    logic       head_reg, head_next;
    logic       tail_reg, tail_next;
    logic [1:0] cnt_reg, cnt_next;

    assign out_valid = (cnt_reg != 2'd0);
    assign deq       = out_valid & ~out_stall;
    assign out_beat  = q_mem_reg[head_reg];
    assign count     = cnt_reg;

    // Pointer and count update
    always_comb
    begin
        head_next = head_reg ^ deq;
        tail_next = tail_reg ^ enq_valid;
        cnt_next  = cnt_reg + {1'b0, enq_valid} - {1'b0, deq};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= 1'b0;
            tail_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Beat storage
    always_ff @(posedge clk)
    begin
        if (enq_valid)
        begin
            q_mem_reg[tail_reg] <= enq_beat;
        end
    end

endmodule

// ===== rtl/core/ring_queue_batch_pop.sv =====
// Ring queue with batch pop: a circular buffer of RING_SIZE words that holds at most
// RING_SIZE-1 of them. A push (command 0) is taken at once and answers with one beat,
// status push accepted or overflow (word dropped when full). A pop (command 1) answers
// "pop none" in one beat if fewer than min_count words are stored or nothing would be
// granted; otherwise it returns min(stored, max_count, 64) words oldest first, each beat
// carrying the total in granted_count and the final one marked by last. The words come
// from the single read port of the ring memory, one per cycle while the output queue has
// room, so in_stall stays high after a pop is taken until its last word is read; pushes
// and empty answers sustain one item per cycle while the output queue has room. A result
// reaches out_valid through the memory read register (descriptor beside it) and the
// output queue; a two-beat output queue lets the next item enter while a beat waits
// under out_stall. The ring memory needs no clearing after reset.
module ring_queue_batch_pop (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           command,
    input  logic [rqbp_pkg::WORD_BITS-1:0] push_value,
    input  logic [rqbp_pkg::CNT_W-1:0]     min_count,
    input  logic [rqbp_pkg::CNT_W-1:0]     max_count,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [rqbp_pkg::STATUS_W-1:0]  status,
    output logic [rqbp_pkg::WORD_BITS-1:0] pop_value,
    output logic [rqbp_pkg::CNT_W-1:0]     granted_count,
    output logic                           last
);
    import rqbp_pkg::*;

    `include "ring_queue_batch_pop_assert.svh"

    logic                 room;
    logic                 busy;
    logic                 ram_wr_en;
    logic [PTR_W-1:0]     ram_wr_addr;
    logic [WORD_BITS-1:0] ram_wr_data;
    logic                 ram_rd_en;
    logic [PTR_W-1:0]     ram_rd_addr;
    logic [WORD_BITS-1:0] ram_rd_data;
    logic                 res_valid;
    res_t                 res;
    beat_t                enq_beat;
    beat_t                out_beat;
    logic [1:0]           q_cnt;
    logic                 deq;
    logic [2:0]           fill_after;

    rqbp_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .push_value  (push_value),
        .min_count   (min_count),
        .max_count   (max_count),
        .room        (room),
        .busy        (busy),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .res_valid   (res_valid),
        .res         (res)
    );

    rqbp_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (RING_SIZE)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Join the read word with its descriptor
    always_comb
    begin
        enq_beat.status  = res.status;
        enq_beat.value   = res.from_ram ? ram_rd_data : '0;
        enq_beat.granted = res.granted;
        enq_beat.last    = res.last;
    end

    rqbp_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .enq_valid (res_valid),
        .enq_beat  (enq_beat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_beat  (out_beat),
        .count     (q_cnt),
        .deq       (deq)
    );

    // Credit: a beat issued now must find a free queue slot next cycle
    assign fill_after = {1'b0, q_cnt} - {2'b0, deq} + {2'b0, res_valid};
    assign room       = (fill_after < 3'd2);

    assign status        = out_beat.status;
    assign pop_value     = out_beat.value;
    assign granted_count = out_beat.granted;
    assign last          = out_beat.last;

    // Checks
    `RQBP_ASSERT_NOW(a_no_queue_overrun, res_valid, !((q_cnt == 2'd2) && !deq))
    `RQBP_ASSERT_NEXT(a_result_reaches_queue, res_valid, out_valid)
    `RQBP_ASSERT_NOW(a_busy_holds_input, busy, in_stall)
    `RQBP_ASSERT_NOW(a_single_beat_fields, out_valid && (status != ST_POPPED), last && (granted_count == '0) && (pop_value == '0))

endmodule

// ===== verif/ring_queue_batch_pop_tb.sv =====
import rqbp_pkg::*;

// Tracks the ring contents and the beats the block owes us
class ring_scoreboard;
    logic [WORD_BITS-1:0] ring_words [RING_SIZE];
    int                   wr_ptr;
    int                   rd_ptr;
    beat_t                due_beats [$];
    int                   errors;

    function new();
        wr_ptr = 0;
        rd_ptr = 0;
        errors = 0;
    endfunction

    function int stored();
        int diff;
        diff = wr_ptr - rd_ptr;
        if (diff < 0)
        begin
            diff += RING_SIZE;
        end
        return diff;
    endfunction

    function int pending();
        return due_beats.size();
    endfunction

    function void queue_beat(logic [STATUS_W-1:0] st, logic [WORD_BITS-1:0] word,
                             int granted, logic is_last);
        beat_t b;
        b.status  = st;
        b.value   = word;
        b.granted = CNT_W'(granted);
        b.last    = is_last;
        due_beats.push_back(b);
    endfunction

    // Work out the beats one accepted item causes and update the ring
    function void predict_beats(logic cmd, logic [WORD_BITS-1:0] word,
                                logic [CNT_W-1:0] min_c, logic [CNT_W-1:0] max_c);
        int next_wr;
        int avail;
        int lim;
        int take;
        if (cmd == CMD_PUSH)
        begin
            next_wr = (wr_ptr + 1) % RING_SIZE;
            if (next_wr == rd_ptr)
            begin
                queue_beat(ST_OVERFLOW, '0, 0, 1'b1);
            end
            else
            begin
                ring_words[wr_ptr] = word;
                wr_ptr = next_wr;
                queue_beat(ST_PUSH_OK, '0, 0, 1'b1);
            end
            return;
        end
        avail = stored();
        lim = int'(max_c);
        if (lim > MAX_GRANT)
        begin
            lim = MAX_GRANT;
        end
        take = (avail > lim) ? lim : avail;
        // below min_count, or nothing to grant: a single "pop none"
        if (avail < int'(min_c) || take == 0)
        begin
            queue_beat(ST_NONE, '0, 0, 1'b1);
            return;
        end
        for (int i = 0; i < take; i++)
        begin
            queue_beat(ST_POPPED, ring_words[(rd_ptr + i) % RING_SIZE], take,
                       (i == take - 1));
        end
        rd_ptr = (rd_ptr + take) % RING_SIZE;
    endfunction

    task report(string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        errors++;
    endtask

    // Compare one output beat against the oldest expectation
    task check_beat(beat_t got);
        beat_t want;
        if (due_beats.size() == 0)
        begin
            report($sformatf("beat with nothing expected: status %0d value %h",
                             got.status, got.value));
            return;
        end
        want = due_beats.pop_front();
        if (got.status !== want.status)
        begin
            report($sformatf("status %0d, want %0d", got.status, want.status));
        end
        if (got.value !== want.value)
        begin
            report($sformatf("pop_value %h, want %h", got.value, want.value));
        end
        if (got.granted !== want.granted)
        begin
            report($sformatf("granted_count %0d, want %0d", got.granted, want.granted));
        end
        if (got.last !== want.last)
        begin
            report($sformatf("last %0b, want %0b", got.last, want.last));
        end
    endtask
endclass

module ring_queue_batch_pop_tb;

    localparam int TOTAL_ITEMS = 370;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT  = 3000;
    localparam int TAIL_CYCLES = 10;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic                 command;
    logic [WORD_BITS-1:0] push_value;
    logic [CNT_W-1:0]     min_count;
    logic [CNT_W-1:0]     max_count;
    logic                 out_valid;
    logic                 out_stall;
    logic [STATUS_W-1:0]  status;
    logic [WORD_BITS-1:0] pop_value;
    logic [CNT_W-1:0]     granted_count;
    logic                 last;

    ring_scoreboard sb;
    int             items_sent;
    int             burst_left;
    bit             gaps_on;
    bit             hold_req;
    int             quiet_cycles;

    ring_queue_batch_pop dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .push_value    (push_value),
        .min_count     (min_count),
        .max_count     (max_count),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .pop_value     (pop_value),
        .granted_count (granted_count),
        .last          (last)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Offer one item, in bursts with random gaps, and wait until it is taken
    task automatic send_item(input logic cmd, input logic [WORD_BITS-1:0] word,
                             input logic [CNT_W-1:0] min_c, input logic [CNT_W-1:0] max_c);
        int gap;
        if (gaps_on && burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            repeat (gap)
            begin
                @(negedge clk);
                in_valid = 1'b0;
            end
            burst_left = $urandom_range(1, 20);
        end
        if (burst_left > 0)
        begin
            burst_left--;
        end
        @(negedge clk);
        in_valid   = 1'b1;
        command    = cmd;
        push_value = word;
        min_count  = min_c;
        max_count  = max_c;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        sb.predict_beats(cmd, word, min_c, max_c);
        items_sent++;
    endtask

    // count fields are don't-care on a push, so fill them with noise
    task automatic push_word(input logic [WORD_BITS-1:0] word);
        send_item(CMD_PUSH, word, CNT_W'($urandom_range(0, 64)),
                  CNT_W'($urandom_range(0, 64)));
    endtask

    task automatic pop_batch(input int min_c, input int max_c);
        send_item(CMD_POP, $urandom, CNT_W'(min_c), CNT_W'(max_c));
    endtask

    // Stop offering and wait for every owed beat
    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Receiver stall pattern, plus a long hold-off on request
    initial
    begin : rx_pattern
        int mode;
        int mode_left;
        int hold_left;
        int tick;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        tick      = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            tick++;
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(30, 150);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall = 1'b1;
            end
            else
            begin
                case (mode)
                    0: out_stall = 1'b0;
                    1: out_stall = 1'($urandom_range(0, 1));
                    2: out_stall = ($urandom_range(0, 3) == 0);
                    default: out_stall = ((tick % 5) < 2);
                endcase
            end
        end
    end

    // Check every accepted output beat
    always @(posedge clk)
    begin : beat_monitor
        beat_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.status  = status;
            got.value   = pop_value;
            got.granted = granted_count;
            got.last    = last;
            sb.check_beat(got);
        end
    end

    // End the run if nothing moves on either side for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int  r;
        int  level;
        int  min_c;
        int  max_c;
        int  fills;
        bit  hold_done;
        bit  pause_done;
        sb           = new();
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        command      = CMD_PUSH;
        push_value   = '0;
        min_count    = '0;
        max_count    = '0;
        items_sent   = 0;
        burst_left   = 0;
        gaps_on      = 1'b0;
        hold_req     = 1'b0;
        fills        = 0;
        hold_done    = 1'b0;
        pause_done   = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty ring, min/max limits, zero grant, ordering
        pop_batch(0, 64);
        pop_batch(1, 1);
        pop_batch(64, 64);
        push_word(32'hFFFF_FFFF);
        push_word(32'h0000_0000);
        push_word(32'hAAAA_AAAA);
        push_word(32'h5555_5555);
        push_word(32'h1234_5678);
        pop_batch(6, 64);
        pop_batch(0, 0);
        pop_batch(5, 0);
        pop_batch(1, 2);
        pop_batch(0, 1);
        pop_batch(3, 64);
        pop_batch(2, 64);
        pop_batch(0, 64);
        push_word(32'h8000_0001);
        pop_batch(1, 1);
        push_word(32'h7FFF_FFFE);
        pop_batch(0, 64);
        wait_drained();

        // Random sequences
        gaps_on = 1'b1;
        while (items_sent < TOTAL_ITEMS)
        begin
            if (!hold_done && items_sent >= 120)
            begin
                // receiver holds off while pushes keep coming
                hold_done = 1'b1;
                hold_req  = 1'b1;
                repeat (12) push_word($urandom);
            end
            if (!pause_done && items_sent >= 240)
            begin
                pause_done = 1'b1;
                wait_drained();
            end
            if ($urandom_range(0, 9) == 0)
            begin
                gaps_on = ($urandom_range(0, 9) < 7);
            end
            r = $urandom_range(0, 99);
            level = sb.stored();
            if (r < 35)
            begin
                repeat ($urandom_range(1, 12)) push_word($urandom);
            end
            else if (r < 70)
            begin
                if ($urandom_range(0, 3) != 0)
                begin
                    min_c = $urandom_range(0, level);
                end
                else
                begin
                    min_c = $urandom_range(0, 64);
                end
                case ($urandom_range(0, 4))
                    0: max_c = $urandom_range(0, 64);
                    1: max_c = 64;
                    default: max_c = $urandom_range(1, 8);
                endcase
                pop_batch(min_c, max_c);
            end
            else if (r < 78 && fills < 3)
            begin
                // fill to capacity, overflow, then take the whole ring
                while (sb.stored() < RING_SIZE - 1)
                begin
                    push_word($urandom);
                end
                repeat ($urandom_range(1, 3)) push_word($urandom);
                pop_batch(64, 64);
                pop_batch(RING_SIZE - 1, 64);
                fills++;
            end
            else if (r < 88)
            begin
                pop_batch(0, 64);
            end
            else
            begin
                send_item(1'($urandom_range(0, 1)), $urandom,
                          CNT_W'($urandom_range(0, 64)), CNT_W'($urandom_range(0, 64)));
            end
        end

        @(negedge clk);
        in_valid = 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
